/* rtl/fbpd_pkg.sv */
package fbpd_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int PALETTE_DEPTH = 16;

  localparam int RowW   = 9;
  localparam int ColW   = 10;
  localparam int ColorW = 24;
  localparam int PalIdxW = $clog2(PALETTE_DEPTH);
  localparam int WordW  = 32;
  localparam int RgbaW  = 32;
  localparam int SrcW   = 19;

  // slave tdata: pal_index, pal_color, pixel_row, pixel_col, fb_word, zero pad
  localparam int InFieldsW = PalIdxW + ColorW + RowW + ColW + WordW;
  localparam int InDataW   = ((InFieldsW + 7) / 8) * 8;
  // master tdata: rgba, source_index, zero pad
  localparam int OutFieldsW = RgbaW + SrcW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam int BarWidth = SCREEN_WIDTH / 8;

  localparam logic [7:0] ALPHA_FULL = 8'hff;

  typedef enum logic [1:0] {
    MODE_BARS   = 2'd0,
    MODE_IDX1   = 2'd1,
    MODE_IDX4   = 2'd2,
    MODE_RGB333 = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_DISPLAY_MODE  = 1'b0,
    CFG_PACKED_LAYOUT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_PAL_WRITE = 1'b0,
    REQ_PIXEL     = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e                req_type;
    logic [PalIdxW-1:0]       pal_index;
    logic [ColorW-1:0]        pal_color;
    logic [RowW-1:0]          pixel_row;
    logic [ColW-1:0]          pixel_col;
    logic [WordW-1:0]         fb_word;
  } fbpd_req_t;

endpackage

/* rtl/framebuffer_pixel_decoder_core.sv */
// Indexed-color pixel decoder for display scan-out.
// Slave stream: tuser is the request kind (0 palette write, 1 pixel request),
// tdata carries the palette entry and color plus the pixel row, column and
// the framebuffer word fetched for it. A palette write makes no output; a
// pixel request makes exactly one master transfer with the ARGB8888 color
// and source word index in tdata and the pixel-valid flag in tuser.
// The cfg channel writes display_mode (index 0) and packed_layout (index 1);
// it is always ready and must only be used while the core is idle.
// Pipeline: an input register and an output register; a pixel result passes
// through both before it shows on the master side. Throughput is one item per
// cycle while the receiver does not stall, set by the single combinational
// decode between the two registers.
// Reset clears the palette to black, the mode registers to color bars /
// unpacked, and both pipeline stages to empty.
// When the receiver stalls, the result holds in the output register and items
// are still taken into the input register until it holds a pixel request;
// s_axis_tready then drops until the output drains.
module framebuffer_pixel_decoder_core
  import fbpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] pal_index, [27:4] pal_color, [36:28] pixel_row, [46:37] pixel_col,
  // [78:47] fb_word, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] rgba, [50:32] source_index, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] pixel_valid
  output logic                m_axis_tuser,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [1:0]          cfg_data_i
);

  mode_e                     mode_q;
  logic                      packed_q;
  logic [ColorW-1:0]         palette_q [PALETTE_DEPTH];

  logic                      s1_valid_q;
  fbpd_req_t                 s1_q;
  logic                      s1_adv;
  logic                      s1_is_write;

  logic                      out_valid_q;
  logic [RgbaW-1:0]          rgba_q, rgba_d;
  logic [SrcW-1:0]           src_q, src_d;
  logic                      pix_valid_q, pix_valid_d;
  logic                      out_free;

  logic [PalIdxW-1:0]        pal_sel;
  logic [ColorW-1:0]         pal_color;
  logic [2:0]                bar;
  logic [RowW-2:0]           r2;
  logic [ColW-2:0]           c2;
  logic [WordW-1:0]          nib_word;

  // ---------------- configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BARS;
      packed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DISPLAY_MODE:  mode_q   <= mode_e'(cfg_data_i);
        CFG_PACKED_LAYOUT: packed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- handshakes
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_is_write   = (s1_q.req_type == REQ_PAL_WRITE);
  // palette writes retire from the input stage without an output slot
  assign s1_adv        = s1_valid_q && (s1_is_write || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_q.req_type  <= req_type_e'(s_axis_tuser);
      s1_q.pal_index <= s_axis_tdata[PalIdxW-1:0];
      s1_q.pal_color <= s_axis_tdata[PalIdxW +: ColorW];
      s1_q.pixel_row <= s_axis_tdata[PalIdxW+ColorW +: RowW];
      s1_q.pixel_col <= s_axis_tdata[PalIdxW+ColorW+RowW +: ColW];
      s1_q.fb_word   <= s_axis_tdata[PalIdxW+ColorW+RowW+ColW +: WordW];
    end
  end

  // ---------------- palette
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        palette_q[i] <= '0;
      end
    end else if (s1_valid_q && s1_is_write) begin
      palette_q[s1_q.pal_index] <= s1_q.pal_color;
    end
  end

  // ---------------- decode
  assign r2       = s1_q.pixel_row[RowW-1:1];
  assign c2       = s1_q.pixel_col[ColW-1:1];
  assign nib_word = s1_q.fb_word >> {c2[2:0], 2'b00};

  always_comb begin
    bar = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (s1_q.pixel_col >= ColW'(k * BarWidth)) bar = 3'(k);
    end
  end

  always_comb begin
    pal_sel = '0;
    if (mode_q == MODE_IDX1) begin
      pal_sel = packed_q ? PalIdxW'(s1_q.fb_word[s1_q.pixel_col[4:0]])
                         : PalIdxW'(s1_q.fb_word[0]);
    end else begin
      pal_sel = packed_q ? nib_word[PalIdxW-1:0] : s1_q.fb_word[PalIdxW-1:0];
    end
  end
  assign pal_color = palette_q[pal_sel];

  always_comb begin
    rgba_d      = '0;
    src_d       = '0;
    pix_valid_d = 1'b1;
    unique case (mode_q)
      MODE_BARS: begin
        rgba_d = {ALPHA_FULL, {8{bar[2]}}, {8{bar[1]}}, {8{bar[0]}}};
      end
      MODE_IDX1: begin
        rgba_d = {ALPHA_FULL, pal_color};
        if (packed_q) begin
          src_d = SrcW'(s1_q.pixel_row) * SrcW'(SCREEN_WIDTH / 32)
                + SrcW'(s1_q.pixel_col >> 5);
        end else begin
          src_d = SrcW'(s1_q.pixel_row) * SrcW'(SCREEN_WIDTH)
                + SrcW'(s1_q.pixel_col);
        end
      end
      MODE_IDX4: begin
        rgba_d = {ALPHA_FULL, pal_color};
        if (packed_q) begin
          src_d = SrcW'(r2) * SrcW'(SCREEN_WIDTH / 16) + SrcW'(c2 >> 3);
        end else begin
          src_d = SrcW'(r2) * SrcW'(SCREEN_WIDTH / 2) + SrcW'(c2);
        end
      end
      MODE_RGB333: begin
        if (packed_q) begin
          pix_valid_d = 1'b0;
        end else begin
          rgba_d = {ALPHA_FULL, s1_q.fb_word[8:6], 5'd0, s1_q.fb_word[5:3], 5'd0,
                    s1_q.fb_word[2:0], 5'd0};
          src_d  = SrcW'(s1_q.pixel_row >> 2) * SrcW'(SCREEN_WIDTH / 4)
                 + SrcW'(s1_q.pixel_col >> 2);
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && !s1_is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q && !s1_is_write) begin
      rgba_q      <= rgba_d;
      src_q       <= src_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutFieldsW){1'b0}}, src_q, rgba_q};
  assign m_axis_tuser  = pix_valid_q;

`ifndef SYNTHESIS
  a_invalid_only_rgb333_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pix_valid_q |-> mode_q == MODE_RGB333 && packed_q)
    else $error("invalid pixel outside packed RGB333 mode");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pix_valid_q |-> rgba_q == '0 && src_q == '0)
    else $error("invalid pixel carries nonzero payload");

  a_alpha_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pix_valid_q |-> rgba_q[RgbaW-1 -: 8] == ALPHA_FULL)
    else $error("valid pixel without full alpha");

  a_palette_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_is_write |=> palette_q[$past(s1_q.pal_index)] == $past(s1_q.pal_color))
    else $error("palette write lost");
`endif

endmodule
